[design/smrc_pkg.sv]
// Shared constants and control/status types for the stepper move ramp controller.
package smrc_pkg;

    localparam int MotorCountDefault = 6;
    localparam int MotorLanes        = 6;
    localparam int PeriodWidth       = 16;
    localparam int ProdWidth         = 32;
    localparam int CfgIndexWidth     = 2;

    // command codes on the input channel
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_SERIAL = 2'd1;
    localparam logic [1:0] CMD_BUTTON = 2'd2;

    // configuration register indexes
    localparam logic [CfgIndexWidth-1:0] CFG_PERIOD_START = 2'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_PERIOD_END   = 2'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_STEPS        = 2'd2;

    localparam logic [15:0] PeriodStartReset = 16'd1000;
    localparam logic [15:0] PeriodEndReset   = 16'd200;
    localparam logic [15:0] StepsReset       = 16'd800;

    localparam logic [7:0] InstrOffset = 8'h7A;
    localparam logic [7:0] ButtonMax   = 8'h20;

    typedef struct packed {
        logic accept;       // input transaction taken this cycle
        logic mul_en;       // register the ramp product
        logic div_start;    // launch the divider
        logic load_period;  // write the ramp period from the quotient
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;     // output register can take a result this cycle
        logic need_ramp;    // current item needs a new period computed
        logic div_done;     // quotient valid
    } t_dp_status;

endpackage

[design/stepper_move_ramp_controller.sv]
// Each taken input transaction's result is registered straight into the output register.
// Throughput: one item per cycle while the output register can take a result, except
// an item ending a step period and starting a new one, which holds off input while the
// next period is formed (the multiply, the divider launch, the divide, then the load).
// Reset (synchronous, active low) idles the move, clears the output valid flag and
// restores the configuration to 1000 / 200 / 800.
module stepper_move_ramp_controller #(
    parameter int MOTOR_COUNT = smrc_pkg::MotorCountDefault
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [smrc_pkg::CfgIndexWidth-1:0]  i_cfg_index,
    input  logic [15:0]                         i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_cmd,
    input  logic [7:0]                          i_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [5:0]                          o_port_k,
    output logic [5:0]                          o_port_f,
    output logic                                o_busy_res,
    output logic                                o_ready_strobe
);

    smrc_pkg::t_dp_cmd    ctl;
    smrc_pkg::t_dp_status status;

    assign o_cfg_ready = 1'b1;

    smrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (ctl)
    );

    smrc_datapath #(
        .MOTOR_COUNT (MOTOR_COUNT)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (i_cmd),
        .i_data         (i_data),
        .i_out_ready    (i_out_ready),
        .i_ctl          (ctl),
        .o_status       (status),
        .o_out_valid    (o_out_valid),
        .o_port_k       (o_port_k),
        .o_port_f       (o_port_f),
        .o_busy_res     (o_busy_res),
        .o_ready_strobe (o_ready_strobe)
    );

endmodule

[design/smrc_div.sv]
// Restoring divider, 32-bit dividend by 16-bit divisor, one quotient bit per cycle.
module smrc_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [smrc_pkg::ProdWidth-1:0]   i_dividend,
    input  logic [smrc_pkg::PeriodWidth-1:0] i_divisor,
    output logic        o_done,
    output logic [smrc_pkg::ProdWidth-1:0]   o_quotient
);

    localparam int QW = smrc_pkg::ProdWidth;
    localparam int DW = smrc_pkg::PeriodWidth;
    localparam int CW = $clog2(QW);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [DW-1:0] r_rem, n_rem;
    logic [QW-1:0] r_quo, n_quo;
    logic [DW:0]   rem_sh;
    logic [DW:0]   rem_diff;

    always_comb begin
        rem_sh   = {r_rem, r_quo[QW-1]};
        rem_diff = rem_sh - {1'b0, i_divisor};
        n_busy   = r_busy;
        n_done   = 1'b0;
        n_cnt    = r_cnt;
        n_rem    = r_rem;
        n_quo    = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
        end else if (r_busy) begin
            // dividend bits shift out the top while quotient bits enter the bottom
            if (rem_sh >= {1'b0, i_divisor}) begin
                n_rem = rem_diff[DW-1:0];
                n_quo = {r_quo[QW-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[DW-1:0];
                n_quo = {r_quo[QW-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(QW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[design/smrc_ctrl.sv]
// Sequencer: takes items and runs the ramp multiply, divide and period load.
module smrc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  smrc_pkg::t_dp_status i_status,
    output smrc_pkg::t_dp_cmd    o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MUL   = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_START = 2'd3;

    logic [1:0] r_state, n_state;
    logic       accept;

    assign o_in_ready = (r_state == ST_IDLE) && i_status.out_free;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state           = r_state;
        o_cmd.accept      = accept;
        o_cmd.mul_en      = 1'b0;
        o_cmd.div_start   = 1'b0;
        o_cmd.load_period = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_status.need_ramp) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = ST_START;
            end
            ST_START: begin
                // product is registered by now
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV;
            end
            ST_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.load_period = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[design/smrc_datapath.sv]
// Move state, command decode, pin formation, output register and ramp arithmetic.
module smrc_datapath #(
    parameter int MOTOR_COUNT = smrc_pkg::MotorCountDefault
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [smrc_pkg::CfgIndexWidth-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    input  logic [1:0]           i_cmd,
    input  logic [7:0]           i_data,
    input  logic                 i_out_ready,
    input  smrc_pkg::t_dp_cmd    i_ctl,
    output smrc_pkg::t_dp_status o_status,
    output logic                 o_out_valid,
    output logic [5:0]           o_port_k,
    output logic [5:0]           o_port_f,
    output logic                 o_busy_res,
    output logic                 o_ready_strobe
);

    localparam int PW = smrc_pkg::PeriodWidth;
    localparam int XW = smrc_pkg::ProdWidth;
    localparam int ML = smrc_pkg::MotorLanes;
    localparam logic [ML-1:0] PresentMask = ML'((ML + 1)'(1) << MOTOR_COUNT) - ML'(1);

    // configuration
    logic [PW-1:0] r_period_start, r_period_end, r_steps;

    // move state
    logic          r_running, n_running;
    logic [PW-1:0] r_step, n_step;
    logic [PW-1:0] r_tick, n_tick;
    logic [PW-1:0] r_cur, n_cur;
    logic          r_dir, n_dir;
    logic [ML-1:0] r_mask, n_mask;
    logic          r_pins_high, n_pins_high;

    // output register
    logic          r_out_valid;
    logic [5:0]    r_port_k, r_port_f;
    logic          r_busy_res, r_strobe;

    // ramp
    logic [XW-1:0] r_prod;
    logic [PW-1:0] ramp_span;
    logic [PW-1:0] end_held;
    logic          div_done;
    logic [XW-1:0] quotient;
    logic [PW-1:0] q_clamped;

    logic          strobe, need_ramp, do_start;
    logic [7:0]    instr;
    logic [PW-1:0] tick_inc, step_inc;
    logic          one_hot;
    logic [5:0]    pk, pf;
    logic [1:0]    pair;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_start <= smrc_pkg::PeriodStartReset;
            r_period_end   <= smrc_pkg::PeriodEndReset;
            r_steps        <= smrc_pkg::StepsReset;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                smrc_pkg::CFG_PERIOD_START: r_period_start <= i_cfg_data;
                smrc_pkg::CFG_PERIOD_END:   r_period_end   <= i_cfg_data;
                smrc_pkg::CFG_STEPS:        r_steps        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign end_held  = (r_period_end > r_period_start) ? r_period_start : r_period_end;
    assign ramp_span = r_period_start - end_held;
    assign tick_inc  = (r_tick == '1) ? r_tick : r_tick + 1'b1;
    assign step_inc  = (r_step == '1) ? r_step : r_step + 1'b1;
    assign one_hot   = (i_data != '0) && ((i_data & (i_data - 8'd1)) == '0)
                       && (i_data <= smrc_pkg::ButtonMax);

    // next state for the item being offered
    always_comb begin
        n_running   = r_running;
        n_step      = r_step;
        n_tick      = r_tick;
        n_cur       = r_cur;
        n_dir       = r_dir;
        n_mask      = r_mask;
        n_pins_high = r_pins_high;
        strobe      = 1'b0;
        need_ramp   = 1'b0;
        do_start    = 1'b0;
        instr       = smrc_pkg::InstrOffset - i_data;
        case (i_cmd)
            smrc_pkg::CMD_TICK: begin
                if (r_running) begin
                    if (r_pins_high && tick_inc >= r_cur) begin
                        n_pins_high = 1'b0;
                        n_tick      = '0;
                        n_step      = step_inc;
                        if (step_inc >= r_steps) begin
                            n_running = 1'b0;
                            n_cur     = '0;
                            strobe    = 1'b1;
                        end else begin
                            need_ramp = 1'b1;
                        end
                    end else begin
                        n_pins_high = 1'b1;
                        n_tick      = tick_inc;
                    end
                end
            end
            smrc_pkg::CMD_SERIAL: begin
                do_start = !r_running;
            end
            smrc_pkg::CMD_BUTTON: begin
                instr    = {i_data[6:0], 1'b0};
                do_start = !r_running && one_hot;
            end
            default: ;
        endcase
        if (do_start) begin
            n_dir  = ~instr[0];
            n_mask = instr[6:1] & PresentMask;
            n_step = '0;
            n_tick = '0;
            if (r_steps == '0) begin
                n_running   = 1'b0;
                n_cur       = '0;
                n_pins_high = 1'b0;
                strobe      = 1'b1;
            end else begin
                n_running   = 1'b1;
                n_pins_high = 1'b1;
                n_cur       = r_period_start;
            end
        end
    end

    // pins from the state after the item
    always_comb begin
        pk   = '0;
        pf   = '0;
        pair = '0;
        for (int i = 0; i < ML; i++) begin
            pair = {n_pins_high & n_mask[i], n_dir} & {2{PresentMask[i]}};
            if (i < 3) begin
                pk[2*(i%3) +: 2] = pair;
            end else begin
                pf[2*(i%3) +: 2] = pair;
            end
        end
    end

    assign q_clamped = (quotient > XW'(ramp_span)) ? ramp_span : quotient[PW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running   <= 1'b0;
            r_step      <= '0;
            r_tick      <= '0;
            r_cur       <= '0;
            r_dir       <= 1'b0;
            r_mask      <= '0;
            r_pins_high <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.accept) begin
                r_running   <= n_running;
                r_step      <= n_step;
                r_tick      <= n_tick;
                r_cur       <= n_cur;
                r_dir       <= n_dir;
                r_mask      <= n_mask;
                r_pins_high <= n_pins_high;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_ctl.load_period) begin
                r_cur <= r_period_start - q_clamped;
            end
        end
        if (i_ctl.accept) begin
            r_port_k   <= pk;
            r_port_f   <= pf;
            r_busy_res <= n_running;
            r_strobe   <= strobe;
        end
        if (i_ctl.mul_en) begin
            r_prod <= XW'(ramp_span) * XW'(r_step);
        end
    end

    smrc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_ctl.div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_steps),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_status.need_ramp = need_ramp;
    assign o_status.div_done  = div_done;

    assign o_out_valid    = r_out_valid;
    assign o_port_k       = r_port_k;
    assign o_port_f       = r_port_f;
    assign o_busy_res     = r_busy_res;
    assign o_ready_strobe = r_strobe;

endmodule

[bench/smrc_motion_checker.sv]
// Channel monitor for the stepper move ramp controller: predicts every pin result and compares.
`timescale 1ns / 100ps
module smrc_motion_checker #(
    parameter int MOTOR_COUNT = smrc_pkg::MotorCountDefault
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_ready,
    input  logic [smrc_pkg::CfgIndexWidth-1:0] i_cfg_index,
    input  logic [15:0]                        i_cfg_data,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic [1:0]                         i_cmd,
    input  logic [7:0]                         i_data,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic [5:0]                         i_port_k,
    input  logic [5:0]                         i_port_f,
    input  logic                               i_busy_res,
    input  logic                               i_ready_strobe,
    output int                                 o_pending,
    output int                                 o_fail_count
);

    localparam int Lanes = (MOTOR_COUNT > smrc_pkg::MotorLanes) ? smrc_pkg::MotorLanes
                                                                 : MOTOR_COUNT;
    localparam logic [5:0] LaneMask = 6'((1 << Lanes) - 1);

    typedef struct packed {
        logic [5:0] port_k;
        logic [5:0] port_f;
        logic       busy_res;
        logic       ready_strobe;
    } t_pin_result;

    // profile registers
    logic [15:0] period_start_q;
    logic [15:0] period_end_q;
    logic [15:0] steps_q;

    // move state
    logic        moving;
    logic [15:0] steps_done;
    logic [15:0] ticks_in_period;
    logic [15:0] period_now;
    logic        dir_level;
    logic [5:0]  motor_sel;
    logic        step_high;

    t_pin_result pin_expect_q[$];
    int          fail_cnt = 0;

    assign o_fail_count = fail_cnt;

    // product formed at 32 bits, so (start - end) * n never wraps
    function automatic logic [15:0] ramp_period(input logic [15:0] n);
        logic [31:0] s;
        logic [31:0] e;
        logic [31:0] q;
        s = {16'd0, period_start_q};
        e = {16'd0, period_end_q};
        if (e > s) e = s;
        q = ((s - e) * {16'd0, n}) / {16'd0, steps_q};
        if (q > s - e) q = s - e;
        return 16'(s - q);
    endfunction

    function automatic void end_move();
        moving          = 1'b0;
        period_now      = 16'd0;
        step_high       = 1'b0;
        ticks_in_period = 16'd0;
    endfunction

    function automatic logic start_move(input logic [7:0] instr);
        logic ended;
        ended           = 1'b0;
        dir_level       = ~instr[0];
        motor_sel       = instr[6:1] & LaneMask;
        steps_done      = 16'd0;
        ticks_in_period = 16'd0;
        if (steps_q == 16'd0) begin
            end_move();
            ended = 1'b1;
        end else begin
            moving     = 1'b1;
            step_high  = 1'b1;
            period_now = ramp_period(16'd0);
        end
        return ended;
    endfunction

    function automatic logic tick_move();
        logic ended;
        ended = 1'b0;
        if (moving) begin
            if (ticks_in_period != 16'hFFFF) ticks_in_period = ticks_in_period + 16'd1;
            if (step_high && ticks_in_period >= period_now) begin
                step_high       = 1'b0;
                ticks_in_period = 16'd0;
                if (steps_done != 16'hFFFF) steps_done = steps_done + 16'd1;
                if (steps_done >= steps_q) begin
                    end_move();
                    ended = 1'b1;
                end else begin
                    period_now = ramp_period(steps_done);
                end
            end else begin
                step_high = 1'b1;
            end
        end
        return ended;
    endfunction

    function automatic t_pin_result predict_pins(input logic [1:0] cmd, input logic [7:0] data);
        t_pin_result r;
        logic        strobe;
        logic [5:0]  pk;
        logic [5:0]  pf;
        logic [1:0]  pair;
        strobe = 1'b0;
        pk     = '0;
        pf     = '0;
        case (cmd)
            smrc_pkg::CMD_TICK: strobe = tick_move();
            smrc_pkg::CMD_SERIAL: begin
                if (!moving) strobe = start_move(smrc_pkg::InstrOffset - data);
            end
            smrc_pkg::CMD_BUTTON: begin
                // only a single set bit at or below bit 5 is a button
                if (!moving && data != 8'd0 && (data & 8'(data - 8'd1)) == 8'd0
                        && data <= smrc_pkg::ButtonMax)
                    strobe = start_move({data[6:0], 1'b0});
            end
            default: ;
        endcase
        for (int i = 0; i < smrc_pkg::MotorLanes; i++) begin
            if (LaneMask[i]) begin
                pair = {step_high & motor_sel[i], dir_level};
                if (i < 3) pk[2*i +: 2] = pair;
                else pf[2*(i-3) +: 2] = pair;
            end
        end
        r.port_k       = pk;
        r.port_f       = pf;
        r.busy_res     = moving;
        r.ready_strobe = strobe;
        return r;
    endfunction

    task automatic report_field(input string name, input logic [5:0] want, input logic [5:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_pin_result want;
        if (!i_rst_n) begin
            period_start_q = smrc_pkg::PeriodStartReset;
            period_end_q   = smrc_pkg::PeriodEndReset;
            steps_q        = smrc_pkg::StepsReset;
            end_move();
            steps_done     = 16'd0;
            dir_level      = 1'b0;
            motor_sel      = '0;
            pin_expect_q.delete();
        end else begin
            // result side first: a result never belongs to an item taken at the same edge
            if (i_out_valid && i_out_ready) begin
                if (pin_expect_q.size() == 0) begin
                    $error("result transaction with no expected result pending");
                    fail_cnt++;
                end else begin
                    want = pin_expect_q.pop_front();
                    report_field("port_k", want.port_k, i_port_k);
                    report_field("port_f", want.port_f, i_port_f);
                    report_field("busy_res", 6'(want.busy_res), 6'(i_busy_res));
                    report_field("ready_strobe", 6'(want.ready_strobe), 6'(i_ready_strobe));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    smrc_pkg::CFG_PERIOD_START: period_start_q = i_cfg_data;
                    smrc_pkg::CFG_PERIOD_END:   period_end_q   = i_cfg_data;
                    smrc_pkg::CFG_STEPS:        steps_q        = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) pin_expect_q.push_back(predict_pins(i_cmd, i_data));
        end
        o_pending <= pin_expect_q.size();
    end

endmodule

[bench/tb_top.sv]
// Bench top for the stepper move ramp controller: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_top;

    localparam logic [1:0] CmdReserved = 2'd3;
    localparam int RampSettle    = 48;   // covers the multiply/divide pass for a new period
    localparam int RandomPhases  = 8;
    localparam int PhaseItems    = 200;
    localparam int PressureHold  = 400;

    logic                               clk;
    logic                               rst_n     = 1'b0;
    logic                               cfg_valid = 1'b0;
    logic [smrc_pkg::CfgIndexWidth-1:0] cfg_index = smrc_pkg::CFG_PERIOD_START;
    logic [15:0]                        cfg_data  = 16'd0;
    logic                               in_valid  = 1'b0;
    logic [1:0]                         in_cmd    = smrc_pkg::CMD_TICK;
    logic [7:0]                         in_data   = 8'd0;
    logic                               out_ready = 1'b0;
    logic                               hold_out  = 1'b0;

    logic       cfg_ready;
    logic       in_ready;
    logic       out_valid;
    logic [5:0] port_k;
    logic [5:0] port_f;
    logic       busy_res;
    logic       ready_strobe;

    int pending;
    int fail_count;
    int burst_left = 0;

    stepper_move_ramp_controller #(.MOTOR_COUNT(smrc_pkg::MotorCountDefault)) DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_cmd          (in_cmd),
        .i_data         (in_data),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_port_k       (port_k),
        .o_port_f       (port_f),
        .o_busy_res     (busy_res),
        .o_ready_strobe (ready_strobe)
    );

    smrc_motion_checker #(.MOTOR_COUNT(smrc_pkg::MotorCountDefault)) motion_chk (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_cmd          (in_cmd),
        .i_data         (in_data),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_port_k       (port_k),
        .i_port_f       (port_f),
        .i_busy_res     (busy_res),
        .i_ready_strobe (ready_strobe),
        .o_pending      (pending),
        .o_fail_count   (fail_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // bursts of random length with random gaps; valid stays up across a burst
    task automatic send_item(input logic [1:0] c, input logic [7:0] d);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_cmd   <= c;
        in_data  <= d;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(smrc_pkg::CMD_TICK, 8'($urandom));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (RampSettle) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [smrc_pkg::CfgIndexWidth-1:0] idx,
                             input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic load_profile(input logic [15:0] p_start, input logic [15:0] p_end,
                                input logic [15:0] steps);
        wait_drained();
        cfg_write(smrc_pkg::CFG_PERIOD_START, p_start);
        cfg_write(smrc_pkg::CFG_PERIOD_END, p_end);
        cfg_write(smrc_pkg::CFG_STEPS, steps);
        cfg_valid <= 1'b0;
    endtask

    // result side: segments of random stalls or none, plus one long hold-off
    initial begin : result_sink
        int   seg_len;
        logic calm;
        logic pressure_done;
        pressure_done = 1'b0;
        @(posedge clk);
        forever begin
            if (hold_out && !pressure_done) begin
                pressure_done = 1'b1;
                out_ready <= 1'b0;
                repeat (PressureHold) @(posedge clk);
            end
            seg_len = $urandom_range(20, 80);
            calm    = ($urandom_range(0, 3) == 0);
            repeat (seg_len) begin
                out_ready <= calm || ($urandom_range(0, 9) < 7);
                @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        logic [15:0] p_start;
        logic [15:0] p_end;
        logic [15:0] steps;
        int          pick;
        logic [7:0]  d;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle block at the reset profile: nothing may start
        send_item(smrc_pkg::CMD_TICK, 8'h00);
        send_item(CmdReserved, 8'hFF);
        send_item(smrc_pkg::CMD_BUTTON, 8'h00);
        send_item(smrc_pkg::CMD_BUTTON, 8'h40);
        send_item(smrc_pkg::CMD_BUTTON, 8'h80);
        send_item(smrc_pkg::CMD_BUTTON, 8'h03);
        send_item(smrc_pkg::CMD_BUTTON, 8'hFF);

        // one-tick periods stretch to two; commands while busy are dropped
        load_profile(16'd1, 16'd1, 16'd3);
        send_item(smrc_pkg::CMD_SERIAL, 8'hFB);
        send_item(smrc_pkg::CMD_BUTTON, 8'h20);
        send_item(smrc_pkg::CMD_SERIAL, 8'h00);
        send_ticks(6);

        // empty moves end on the command itself
        load_profile(16'd5, 16'hFFFF, 16'd0);
        send_item(smrc_pkg::CMD_BUTTON, 8'h01);
        send_item(smrc_pkg::CMD_SERIAL, 8'h00);

        // zero start period
        load_profile(16'd0, 16'd1, 16'd2);
        send_item(smrc_pkg::CMD_BUTTON, 8'h10);
        send_ticks(4);

        // run 30 short steps, then reprofile so that (start - end) * n passes 16 bits
        load_profile(16'd2, 16'd2, 16'd200);
        send_item(smrc_pkg::CMD_BUTTON, 8'h08);
        send_ticks(60);
        load_profile(16'd2200, 16'd2, 16'd32);
        send_ticks(90);

        // long single period
        load_profile(16'd150, 16'd1, 16'd1);
        send_item(smrc_pkg::CMD_BUTTON, 8'h20);
        send_ticks(155);

        // end above start, maximum steps, then cut the move short mid-way
        load_profile(16'd3, 16'hFFFF, 16'hFFFF);
        send_item(smrc_pkg::CMD_SERIAL, 8'h3C);
        send_ticks(30);
        wait_drained();
        cfg_write(smrc_pkg::CFG_STEPS, 16'd2);
        cfg_valid <= 1'b0;
        send_ticks(12);

        hold_out <= 1'b1;
        for (int ph = 0; ph < RandomPhases; ph++) begin
            p_start = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(9, 40))
                                                   : 16'($urandom_range(0, 10));
            p_end   = 16'($urandom_range(1, 12));
            steps   = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(13, 30))
                                                   : 16'($urandom_range(0, 12));
            load_profile(p_start, p_end, steps);
            repeat (PhaseItems) begin
                pick = $urandom_range(0, 99);
                d    = 8'($urandom);
                if (pick < 78) send_item(smrc_pkg::CMD_TICK, d);
                else if (pick < 85) send_item(smrc_pkg::CMD_SERIAL, d);
                else if (pick < 95)
                    send_item(smrc_pkg::CMD_BUTTON,
                              ($urandom_range(0, 3) != 0) ? 8'(1 << $urandom_range(0, 5)) : d);
                else send_item(CmdReserved, d);
            end
        end

        wait_drained();
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // 10 ms at 10 ns per cycle
    initial begin : watchdog
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
